// ===== rtl/core/ece_pkg.sv =====
// Shared types and constants for the easing curve evaluator.
// Holds the curve code enum, the port widths and the fixed constants used to build the sine table.
// No dependencies.
package ece_pkg;

	typedef enum logic [3:0] {
		CURVE_LINEAR       = 4'd0,
		CURVE_IN_QUAD      = 4'd1,
		CURVE_OUT_QUAD     = 4'd2,
		CURVE_IN_OUT_QUAD  = 4'd3,
		CURVE_IN_CUBIC     = 4'd4,
		CURVE_OUT_CUBIC    = 4'd5,
		CURVE_IN_OUT_CUBIC = 4'd6,
		CURVE_IN_SINE      = 4'd7,
		CURVE_OUT_SINE     = 4'd8,
		CURVE_IN_OUT_SINE  = 4'd9
	} curve_op_t;

	// pi/2 in Q30.
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	// Taylor series divisors (2n)(2n+1) for the sine terms up to x^21.
	localparam logic [63:0] TAYLOR_DIV [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	localparam int OUT_W = 17;
	localparam int PROG_W = 18;

endpackage

// ===== rtl/core/easing_curve_evaluator.sv =====
// Easing curve evaluator: top level, a six-stage pipeline with a sine table ROM.
// Depends on ece_pkg for the curve codes and the sine table constants.
//
//   Channel   Handshake              Word
//   input     in_valid / in_ready    operation[3:0], progress[17:0] (signed Q2.16)
//   output    out_valid / out_ready  eased[16:0] (unsigned, 1.0 = 2^FRACTION_BITS)
//
// An accepted word passes through stages 1 to 6; the result word is registered in stage 6.
// One word can enter in every cycle while the output is not blocked; the throughput is then one result per cycle.
// Each stage holds its word while the next stage is full and blocked, so bubbles
// are squeezed out and in_ready only drops when all six stages hold a word.
// Reset clears the valid bits only; the sine table is a constant ROM with no fill.
module easing_curve_evaluator
	import ece_pkg::*;
#(
	parameter int FRACTION_BITS      = 16,
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               operation,
	input  logic signed [PROG_W-1:0] progress,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OUT_W-1:0]         eased
);

	// Widths. TW holds 0..ONE. AW addresses the N+1 table entries, JW holds 0..2N.
	localparam int TW = FRACTION_BITS + 1;
	localparam int AW = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int JW = $clog2(2 * SINE_TABLE_ENTRIES + 1);
	localparam int MW = FRACTION_BITS + JW + 1;
	localparam int PW = 2 * TW;
	localparam int CW = (TW > PROG_W) ? TW : PROG_W;

	localparam logic [TW-1:0] ONE  = TW'(1) << FRACTION_BITS;
	localparam logic [TW-1:0] HALF = TW'(1) << (FRACTION_BITS - 1);
	localparam logic [MW-1:0] N_M  = MW'(SINE_TABLE_ENTRIES);

	typedef logic [TW-1:0] sine_rom_t [0:SINE_TABLE_ENTRIES];

	// One sine table entry: Taylor series in Q30 with each term truncated, then
	// rounded to the fraction width and clamped to 0..ONE.
	function automatic logic [TW-1:0] sine_entry(input logic [63:0] k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [65:0] sum;
		logic [63:0]        e;
		x = (PI_HALF_Q30 * k + 64'(SINE_TABLE_ENTRIES / 2)) / SINE_TABLE_ENTRIES;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed({2'b00, x});
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n % 2 == 1) begin
				sum = sum - $signed({2'b00, term});
			end else begin
				sum = sum + $signed({2'b00, term});
			end
		end
		if (sum[65]) begin
			return '0;
		end
		e = (sum[63:0] + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
		if (e > 64'(ONE)) begin
			return ONE;
		end
		return TW'(e);
	endfunction

	function automatic sine_rom_t build_rom();
		sine_rom_t rom;
		for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
			rom[k] = sine_entry(64'(k));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	// Stage handshake: a stage takes a new word when it is empty or its word moves on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: clamp progress to 0..ONE. Negative values go to zero.
	logic [CW-1:0] prog_ext;
	logic [TW-1:0] t_clamp;

	assign prog_ext = CW'(progress[PROG_W-2:0]);

	always_comb begin
		if (progress[PROG_W-1]) begin
			t_clamp = '0;
		end else if (prog_ext > CW'(ONE)) begin
			t_clamp = ONE;
		end else begin
			t_clamp = TW'(prog_ext);
		end
	end

	curve_op_t     op_s1;
	logic [TW-1:0] t_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= curve_op_t'(operation);
			t_s1  <= t_clamp;
		end
	end

	// Stage 2: pick the operand that gets squared and form the sine table address.
	// For the quadratic and cubic in-out curves at or above one half the operand is u = 2*ONE - 2*t.
	logic          half_c;
	logic [TW-1:0] a_c;
	logic [MW-1:0] k_full, j_full, k_c, j_c;
	logic [AW-1:0] addr_c;
	logic          shi_c;

	assign half_c = t_s1 >= HALF;
	assign k_full = (MW'(t_s1) * N_M + MW'(HALF)) >> FRACTION_BITS;
	assign j_full = ((MW'(t_s1) * N_M << 1) + MW'(HALF)) >> FRACTION_BITS;
	assign k_c    = (k_full > N_M) ? N_M : k_full;
	assign j_c    = (j_full > (N_M << 1)) ? (N_M << 1) : j_full;
	assign shi_c  = j_c > N_M;

	always_comb begin
		case (op_s1)
			CURVE_OUT_QUAD, CURVE_OUT_CUBIC: begin
				a_c = ONE - t_s1;
			end
			CURVE_IN_OUT_QUAD, CURVE_IN_OUT_CUBIC: begin
				a_c = half_c ? TW'((ONE - t_s1) << 1) : t_s1;
			end
			default: begin
				a_c = t_s1;
			end
		endcase
	end

	always_comb begin
		case (op_s1)
			CURVE_IN_SINE: begin
				addr_c = AW'(N_M - k_c);
			end
			CURVE_OUT_SINE: begin
				addr_c = AW'(k_c);
			end
			CURVE_IN_OUT_SINE: begin
				addr_c = shi_c ? AW'(j_c - N_M) : AW'(N_M - j_c);
			end
			default: begin
				addr_c = '0;
			end
		endcase
	end

	curve_op_t     op_s2;
	logic [TW-1:0] t_s2, a_s2;
	logic          half_s2, shi_s2;
	logic [AW-1:0] addr_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op_s1;
			t_s2    <= t_s1;
			a_s2    <= a_c;
			half_s2 <= half_c;
			shi_s2  <= shi_c;
			addr_s2 <= addr_c;
		end
	end

	// Stage 3: square the operand and read the sine table.
	curve_op_t     op_s3;
	logic [TW-1:0] t_s3, a_s3, rom_s3;
	logic          half_s3, shi_s3;
	logic [PW-1:0] p1_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3   <= op_s2;
			t_s3    <= t_s2;
			a_s3    <= a_s2;
			half_s3 <= half_s2;
			shi_s3  <= shi_s2;
			p1_s3   <= PW'(a_s2) * PW'(a_s2);
			rom_s3  <= SINE_ROM[addr_s2];
		end
	end

	// Stage 4: round the square, finish the linear, quadratic and sine curves.
	logic [TW-1:0] sq_c, res4_c;
	logic [TW:0]   sv_c;

	assign sq_c = TW'((p1_s3 + PW'(HALF)) >> FRACTION_BITS);
	assign sv_c = shi_s3 ? ((TW + 1)'(ONE) + (TW + 1)'(rom_s3))
	                     : (TW + 1)'(ONE - rom_s3);

	always_comb begin
		case (op_s3)
			CURVE_IN_QUAD: begin
				res4_c = sq_c;
			end
			CURVE_OUT_QUAD: begin
				res4_c = ONE - sq_c;
			end
			CURVE_IN_OUT_QUAD: begin
				if (half_s3) begin
					res4_c = ONE - TW'((p1_s3 + PW'(ONE)) >> (FRACTION_BITS + 1));
				end else begin
					res4_c = TW'(((p1_s3 << 1) + PW'(HALF)) >> FRACTION_BITS);
				end
			end
			CURVE_IN_SINE: begin
				res4_c = ONE - rom_s3;
			end
			CURVE_OUT_SINE: begin
				res4_c = rom_s3;
			end
			CURVE_IN_OUT_SINE: begin
				res4_c = TW'((sv_c + (TW + 1)'(1)) >> 1);
			end
			default: begin
				res4_c = t_s3;
			end
		endcase
	end

	curve_op_t     op_s4;
	logic [TW-1:0] a_s4, sq_s4, res_s4;
	logic          half_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4   <= op_s3;
			a_s4    <= a_s3;
			sq_s4   <= sq_c;
			half_s4 <= half_s3;
			res_s4  <= res4_c;
		end
	end

	// Stage 5: operand times its rounded square, for the cubic curves.
	curve_op_t     op_s5;
	logic [TW-1:0] res_s5;
	logic          half_s5;
	logic [PW-1:0] p2_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			op_s5   <= op_s4;
			res_s5  <= res_s4;
			half_s5 <= half_s4;
			p2_s5   <= PW'(a_s4) * PW'(sq_s4);
		end
	end

	// Stage 6: finish the cubic curves, saturate to ONE, register the result word.
	logic [TW-1:0] cube_c, res6_c, fin_c;

	assign cube_c = TW'((p2_s5 + PW'(HALF)) >> FRACTION_BITS);

	always_comb begin
		case (op_s5)
			CURVE_IN_CUBIC: begin
				res6_c = cube_c;
			end
			CURVE_OUT_CUBIC: begin
				res6_c = ONE - cube_c;
			end
			CURVE_IN_OUT_CUBIC: begin
				if (half_s5) begin
					res6_c = ONE - TW'((p2_s5 + PW'(ONE)) >> (FRACTION_BITS + 1));
				end else begin
					res6_c = TW'(((p2_s5 << 2) + PW'(HALF)) >> FRACTION_BITS);
				end
			end
			default: begin
				res6_c = res_s5;
			end
		endcase
	end

	assign fin_c = (res6_c > ONE) ? ONE : res6_c;

	logic [OUT_W-1:0] eased_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			eased_s6 <= OUT_W'(fin_c);
		end
	end

	assign out_valid = v_s6;
	assign eased     = eased_s6;

	// The input is only held off when every stage holds a word.
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input blocked while the pipeline has a free stage");

	// The table address never points past the last entry.
	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (32'(addr_s2) <= 32'(SINE_TABLE_ENTRIES)))
		else $error("sine table address out of range");

	// The rounded square of an operand in 0..ONE stays within 0..ONE.
	a_square_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (sq_s4 <= ONE))
		else $error("rounded square above one");

	// A result word only appears after a word sat in the stage before it.
	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s6) |-> $past(v_s5))
		else $error("output word without a source");

	// The result never exceeds one when the full-scale value fits the word.
	a_out_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (FRACTION_BITS > 16 || 32'(eased) <= 32'(ONE)))
		else $error("result word above one");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the easing curve evaluator (top module tb).
// Drives curve/progress words through valid/ready, predicts every result, and compares.
// Depends on ece_pkg and easing_curve_evaluator from the RTL.
module tb
	import ece_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Block configuration as instantiated; the predictor is built for the same values.
	localparam int FRAC = 16;
	localparam int TABLE_N = 1024;
	localparam longint unsigned ONE = 64'd1 << FRAC;
	localparam longint unsigned HALF = ONE >> 1;
	localparam longint unsigned QN = TABLE_N;

	// Codes above the last named curve; the block treats them as linear.
	localparam logic [3:0] CURVE_SPARE_LO = 4'd10;
	localparam logic [3:0] CURVE_SPARE_HI = 4'd15;

	// One pending input word, and one expected result with the word that caused it.
	typedef struct packed {
		logic [3:0]         op;
		logic signed [17:0] prog;
	} ease_word_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [17:0] prog;
		logic [16:0] eased;
	} eased_due_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Every block input starts at a known value before reset is applied.
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [3:0]               operation = CURVE_LINEAR;
	logic signed [PROG_W-1:0] progress = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [OUT_W-1:0]         eased;

	ease_word_t stim_words[$];
	eased_due_t eased_due[$];

	// Quarter-wave sine table, rebuilt here from the Taylor series in Q30.
	longint unsigned quarter_sine [0:TABLE_N];

	int faults = 0;
	int words_sent = 0;
	int words_checked = 0;
	int neg_words = 0;
	int over_words = 0;

	int idle_left = 0;
	int stall_left = 0;

	// When calm is set, neither side inserts gaps, so the pipeline runs back to back.
	logic calm = 1'b0;
	int calm_left = 0;

	easing_curve_evaluator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.progress  (progress),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.eased     (eased)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sine of pi/2 * k/N: x in Q30, x and then ten truncated Taylor terms, rounded to the
	// output fraction and clamped to one.
	function automatic longint unsigned sine_entry(longint unsigned k);
		longint unsigned x, x2, term, s, e;
		longint sum;
		x = (PI_HALF_Q30 * k + QN / 2) / QN;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			return 0;
		end
		s = longint'(sum);
		e = (s + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		return (e > ONE) ? ONE : e;
	endfunction

	function automatic longint unsigned rnd(longint unsigned x);
		return (x + HALF) >> FRAC;
	endfunction

	function automatic longint unsigned square_q(longint unsigned a);
		return rnd(a * a);
	endfunction

	function automatic longint unsigned cube_q(longint unsigned a);
		return rnd(a * square_q(a));
	endfunction

	function automatic longint unsigned floor_sub(longint unsigned a, longint unsigned b);
		return (b > a) ? 0 : a - b;
	endfunction

	// Expected eased value for one word: clamp progress to 0..1, apply the curve,
	// saturate at one.
	function automatic logic [16:0] ease_predict(logic [3:0] op, logic signed [17:0] prog);
		longint unsigned t, u, k, j, v, r;
		if (prog[17]) begin
			t = 0;
		end else begin
			t = 64'(prog[16:0]);
			if (t > ONE) begin
				t = ONE;
			end
		end
		u = 2 * ONE - 2 * t;
		k = (t * QN + HALF) >> FRAC;
		if (k > QN) begin
			k = QN;
		end
		j = (2 * t * QN + HALF) >> FRAC;
		if (j > 2 * QN) begin
			j = 2 * QN;
		end
		case (curve_op_t'(op))
			CURVE_IN_QUAD: begin
				r = square_q(t);
			end
			CURVE_OUT_QUAD: begin
				r = floor_sub(ONE, square_q(ONE - t));
			end
			CURVE_IN_OUT_QUAD: begin
				if (t < HALF) begin
					r = rnd(2 * t * t);
				end else begin
					r = floor_sub(ONE, (u * u + ONE) >> (FRAC + 1));
				end
			end
			CURVE_IN_CUBIC: begin
				r = cube_q(t);
			end
			CURVE_OUT_CUBIC: begin
				r = floor_sub(ONE, cube_q(ONE - t));
			end
			CURVE_IN_OUT_CUBIC: begin
				if (t < HALF) begin
					r = rnd(4 * t * square_q(t));
				end else begin
					r = floor_sub(ONE, (u * square_q(u) + ONE) >> (FRAC + 1));
				end
			end
			CURVE_IN_SINE: begin
				r = floor_sub(ONE, quarter_sine[QN - k]);
			end
			CURVE_OUT_SINE: begin
				r = quarter_sine[k];
			end
			CURVE_IN_OUT_SINE: begin
				// The first half runs the table backwards, the second half forwards
				// on top of one; the sum is then halved with rounding.
				if (j <= QN) begin
					v = floor_sub(ONE, quarter_sine[QN - j]);
				end else begin
					v = ONE + quarter_sine[j - QN];
				end
				r = (v + 1) >> 1;
			end
			default: begin
				r = t;
			end
		endcase
		if (r > ONE) begin
			r = ONE;
		end
		return r[16:0];
	endfunction

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Progress values lean toward the useful 0..1 span, with a share below zero,
	// above one, and right at the edges and the midpoint.
	function automatic logic [17:0] pick_progress();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return 18'($urandom_range(131072, 262143));
		end else if (r < 20) begin
			return 18'($urandom_range(65537, 131071));
		end else if (r < 24) begin
			return 18'($urandom_range(0, 8));
		end else if (r < 28) begin
			return 18'($urandom_range(32760, 32776));
		end else if (r < 32) begin
			return 18'($urandom_range(65528, 65536));
		end
		return 18'($urandom_range(0, 65536));
	endfunction

	task automatic queue_word(logic [3:0] op, logic signed [17:0] prog);
		ease_word_t w;
		w.op = op;
		w.prog = prog;
		stim_words.push_back(w);
	endtask

	// Flip between calm stretches and normal, gappy traffic every so often.
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm <= ($urandom_range(0, 3) == 0);
			calm_left <= $urandom_range(40, 200);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// Driver: an accepted word gets its prediction queued at the same edge. A new word
	// is only presented once the previous one is taken, so valid never drops early.
	always @(posedge clk or negedge arst_n) begin : driver
		ease_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= CURVE_LINEAR;
			progress <= '0;
			idle_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				eased_due.push_back('{op: operation, prog: progress,
					eased: ease_predict(operation, progress)});
				words_sent++;
				if (progress[17]) begin
					neg_words++;
				end else if (progress > 18'sd65536) begin
					over_words++;
				end
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					in_valid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (stim_words.size() > 0) begin
					w = stim_words.pop_front();
					operation <= w.op;
					progress <= w.prog;
					in_valid <= 1'b1;
					idle_left <= calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare every accepted result word with the oldest prediction, then
	// decide whether the receiver stalls in the next cycles.
	always @(posedge clk or negedge arst_n) begin : monitor
		eased_due_t due_w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (eased_due.size() == 0) begin
					faults++;
					if (faults <= 10) begin
						$display("%0t: result word %0d with no word outstanding", $realtime,
							eased);
					end
				end else begin
					due_w = eased_due.pop_front();
					words_checked++;
					if (eased !== due_w.eased) begin
						faults++;
						if (faults <= 10) begin
							$display("%0t: curve %0d progress %0d: expected %0d, got %0d",
								$realtime, due_w.op, $signed(due_w.prog), due_w.eased,
								eased);
						end
					end
				end
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 20) begin
					stall_left <= pick_gap();
				end
			end
		end
	end

	initial begin
		for (int k = 0; k <= TABLE_N; k++) begin
			quarter_sine[k] = sine_entry(64'(k));
		end

		// Directed words: the clamp on both sides, zero and one, both sides of the
		// midpoint for the in-out curves, and the spare codes that fall back to linear.
		queue_word(CURVE_LINEAR, -18'sd131072);
		queue_word(CURVE_IN_QUAD, 18'sd131071);
		queue_word(CURVE_OUT_QUAD, 18'sd0);
		queue_word(CURVE_IN_OUT_QUAD, 18'sd32767);
		queue_word(CURVE_IN_OUT_QUAD, 18'sd32768);
		queue_word(CURVE_IN_CUBIC, 18'sd32768);
		queue_word(CURVE_OUT_CUBIC, 18'sd65535);
		queue_word(CURVE_IN_OUT_CUBIC, 18'sd32767);
		queue_word(CURVE_IN_OUT_CUBIC, 18'sd32768);
		queue_word(CURVE_IN_SINE, 18'sd65536);
		queue_word(CURVE_IN_SINE, 18'sd1);
		queue_word(CURVE_OUT_SINE, 18'sd65537);
		queue_word(CURVE_OUT_SINE, 18'sd0);
		queue_word(CURVE_IN_OUT_SINE, 18'sd32767);
		queue_word(CURVE_IN_OUT_SINE, 18'sd32768);
		queue_word(CURVE_IN_OUT_SINE, 18'sd65536);
		queue_word(CURVE_SPARE_LO, 18'sd12345);
		queue_word(CURVE_SPARE_HI, -18'sd1);
		queue_word(CURVE_SPARE_HI, 18'sd65536);
		queue_word(CURVE_SPARE_LO, 18'sd1);
		queue_word(CURVE_IN_QUAD, 18'sd65536);
		queue_word(CURVE_OUT_QUAD, 18'sd65536);
		queue_word(CURVE_IN_CUBIC, 18'sd65536);
		queue_word(CURVE_OUT_CUBIC, 18'sd0);
		queue_word(CURVE_LINEAR, 18'sd65536);

		// Random words: mostly the named curves, some spare codes.
		for (int i = 0; i < 850; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_word(4'($urandom_range(CURVE_SPARE_LO, CURVE_SPARE_HI)),
					pick_progress());
			end else begin
				queue_word(4'($urandom_range(CURVE_LINEAR, CURVE_IN_OUT_SINE)),
					pick_progress());
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_words.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (eased_due.size() != 0) begin
			@(posedge clk);
		end
		// Six pipeline stages; anything that shows up after this is a stray word.
		repeat (16) @(posedge clk);

		if (eased_due.size() != 0) begin
			$display("%0d predicted words never came out", eased_due.size());
		end
		$display("Sent %0d words and checked %0d results over all 16 curve codes.",
			words_sent, words_checked);
		$display("Of those, %0d had negative progress and %0d progress above one; %0d faults.",
			neg_words, over_words, faults);
		if (faults == 0 && eased_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#10ms;
		$display("Timed out with %0d words still to send and %0d results due",
			stim_words.size(), eased_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
